/* rtl/core/tjps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tjps_pkg : joint servo shared definitions
// Register indexes, drive mode codes, fixed point limits and gain tables.
// ----------------------------------------------------------------------------
package tjps_pkg;

	localparam int ANGLE_W = 16;
	localparam int DRIVE_W = 32;
	localparam int JIDX_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// 3 degrees in Q3.12, rounded to nearest
	localparam logic signed [ANGLE_W:0] MAX_ERR = 17'sd214;

	localparam logic [15:0] RATE_RESET = 16'd1000;

	localparam logic [1:0] MODE_TORQUE = 2'd0;
	localparam logic [1:0] MODE_VEL    = 2'd1;
	localparam logic [1:0] MODE_POS    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE  = 2'd2;

	localparam logic [2:0] GAIN_LAST_ARM = 3'd5;
	localparam logic [2:0] GAIN_FINGER   = 3'd6;

	typedef logic [9:0] kp_t;
	typedef logic [7:0] kd2_t;

	function automatic kp_t kp_gain(input logic fast, input logic [2:0] g);
		kp_t k;
		begin
			case (g)
				3'd0, 3'd1: k = fast ? 10'd1000 : 10'd400;
				3'd2:       k = fast ? 10'd600  : 10'd150;
				3'd3, 3'd4: k = fast ? 10'd300  : 10'd60;
				3'd5:       k = fast ? 10'd250  : 10'd60;
				default:    k = fast ? 10'd30   : 10'd5;
			endcase
			return k;
		end
	endfunction

	// derivative gain held doubled so that it stays an integer
	function automatic kd2_t kd2_gain(input logic fast, input logic [2:0] g);
		kd2_t k;
		begin
			case (g)
				3'd0, 3'd1: k = fast ? 8'd200 : 8'd60;
				3'd2:       k = fast ? 8'd120 : 8'd30;
				3'd3, 3'd4: k = fast ? 8'd60  : 8'd10;
				3'd5:       k = fast ? 8'd50  : 8'd10;
				default:    k = fast ? 8'd6   : 8'd1;
			endcase
			return k;
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/core/teleop_joint_pd_servo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// teleop_joint_pd_servo : arm joint position servo
// Per-joint target tracking with limit and error clamping, shared finger
// target, and PD torque / velocity / position drive output.
// ----------------------------------------------------------------------------
// One beat per joint and tick. A beat with a joint index below JOINT_COUNT
// gives one result beat; any other index is taken and dropped with no
// result. All products go through one 34x18 signed multiplier under a
// small sequencer, so beats are spaced by the multiplier passes of the mode:
// three passes in torque mode, one in velocity mode and none in position
// mode or the unused mode. A finished result sits in an output register, so
// the next beat is taken while it waits.
module teleop_joint_pd_servo #(
	parameter int JOINT_COUNT = 9
) (
	input  wire         clk,
	input  wire         arst_n,
	// config
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_wdata,
	// input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	// joint_index[3:0], angle_now[19:4], angle_low_limit[35:20],
	// angle_high_limit[51:36], target_step[67:52], zero [71:68]
	input  wire  [71:0] s_tdata,
	// start_req[0]
	input  wire  [0:0]  s_tuser,
	// output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	// joint_out[3:0], drive_value[35:4], clamped_target[51:36], zero [55:52]
	output logic [55:0] m_tdata
);

	localparam int IDX_W        = $clog2(JOINT_COUNT);
	localparam int FINGER_FIRST = JOINT_COUNT - 3;
	localparam int ACC_W        = 48;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_LOAD     = 3'd1;
	localparam logic [2:0] ST_CLAMP    = 3'd2;
	localparam logic [2:0] ST_MUL_KP   = 3'd3;
	localparam logic [2:0] ST_MUL_RATE = 3'd4;
	localparam logic [2:0] ST_MUL_KD   = 3'd5;
	localparam logic [2:0] ST_FINAL    = 3'd6;

	// config registers
	logic [1:0]  mode_q;
	logic        fast_q;
	logic [15:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tjps_pkg::MODE_TORQUE;
			fast_q <= 1'b0;
			rate_q <= tjps_pkg::RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tjps_pkg::CFG_DRIVE_MODE: mode_q <= cfg_wdata[1:0];
				tjps_pkg::CFG_FAST_GAIN:  fast_q <= cfg_wdata[0];
				tjps_pkg::CFG_STEP_RATE:  rate_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [2:0] state_q;
	logic       fix_q;
	logic       out_load;

	// beat fields
	logic [3:0]         j_q;
	logic               start_q;
	logic signed [15:0] now_q, lo_q, hi_q, step_q;

	// joint state
	logic signed [15:0] target_q [JOINT_COUNT];
	logic signed [15:0] prev_q   [JOINT_COUNT];
	logic signed [15:0] shared_q;
	logic signed [15:0] span_hi_q, span_lo_q;

	// working registers
	logic signed [16:0] want_q, lower_q, upper_q;
	logic signed [15:0] prev_base_q, t_q;
	logic signed [16:0] e_q, dq_q;
	tjps_pkg::kp_t      kp_q;
	tjps_pkg::kd2_t     kd2_q;
	logic signed [51:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	// output register
	logic               m_valid_q;
	logic [3:0]         jout_q;
	logic signed [31:0] drive_q;
	logic signed [15:0] clamped_q;

	logic [IDX_W-1:0] idx;
	logic is_finger, is_first, is_last, in_range;

	assign idx       = j_q[IDX_W-1:0];
	assign is_finger = j_q >= 4'(FINGER_FIRST);
	assign is_first  = j_q == 4'(FINGER_FIRST);
	assign is_last   = j_q == 4'(JOINT_COUNT - 1);
	assign in_range  = {1'b0, s_tdata[3:0]} < 5'(JOINT_COUNT);

	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FINAL) && (!m_valid_q || m_tready);

	// load step: stored target, shared finger target and clamp window
	logic signed [15:0] shared_base, tgt_base;
	logic signed [16:0] shared_sum, near_lo, near_hi;
	logic signed [15:0] shared_sat;
	logic [2:0]         gsel;

	always_comb begin
		shared_base = (start_q && is_first) ? now_q : shared_q;
		shared_sum  = 17'(shared_base) + 17'(step_q);
		if (shared_sum > 17'sd32767)
			shared_sat = 16'sh7fff;
		else if (shared_sum < -17'sd32768)
			shared_sat = 16'sh8000;
		else
			shared_sat = shared_sum[15:0];
		tgt_base = start_q ? now_q : target_q[idx];
		near_lo  = 17'(now_q) - tjps_pkg::MAX_ERR;
		near_hi  = 17'(now_q) + tjps_pkg::MAX_ERR;
		if (is_finger)
			gsel = tjps_pkg::GAIN_FINGER;
		else if (j_q > 4'(tjps_pkg::GAIN_LAST_ARM))
			gsel = tjps_pkg::GAIN_LAST_ARM;
		else
			gsel = j_q[2:0];
	end

	// clamp step
	logic signed [15:0] t_new;

	always_comb begin
		if (want_q < lower_q)
			t_new = lower_q[15:0];
		else if (want_q > upper_q)
			t_new = upper_q[15:0];
		else
			t_new = want_q[15:0];
	end

	// shared multiplier
	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [51:0] mul_p;

	always_comb begin
		case (state_q)
			ST_MUL_RATE: begin
				mul_a = 34'((mode_q == tjps_pkg::MODE_TORQUE) ? dq_q : e_q);
				mul_b = $signed({2'b00, rate_q});
			end
			ST_MUL_KD: begin
				mul_a = prod_q[33:0];
				mul_b = $signed({10'd0, kd2_q});
			end
			default: begin
				mul_a = 34'(e_q);
				mul_b = $signed({8'd0, kp_q});
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// final sum and saturation
	logic signed [ACC_W-1:0] sum;
	logic signed [31:0]      drive_sat;

	always_comb begin
		case (mode_q)
			tjps_pkg::MODE_TORQUE: sum = acc_q - (ACC_W'(prod_q) <<< 3);
			tjps_pkg::MODE_VEL:    sum = ACC_W'(prod_q) <<< 3;
			tjps_pkg::MODE_POS:    sum = ACC_W'(t_q) <<< 4;
			default:               sum = '0;
		endcase
		if (sum[ACC_W-1:31] == '0 || sum[ACC_W-1:31] == '1)
			drive_sat = sum[31:0];
		else if (sum[ACC_W-1])
			drive_sat = 32'sh8000_0000;
		else
			drive_sat = 32'sh7fff_ffff;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fix_q   <= 1'b0;
		end else begin
			fix_q <= (state_q == ST_CLAMP) && is_finger && is_last;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && in_range)
						state_q <= ST_LOAD;
				end
				ST_LOAD:  state_q <= ST_CLAMP;
				ST_CLAMP: begin
					if (mode_q == tjps_pkg::MODE_TORQUE)
						state_q <= ST_MUL_KP;
					else if (mode_q == tjps_pkg::MODE_VEL)
						state_q <= ST_MUL_RATE;
					else
						state_q <= ST_FINAL;
				end
				ST_MUL_KP: state_q <= ST_MUL_RATE;
				ST_MUL_RATE: begin
					if (mode_q == tjps_pkg::MODE_TORQUE)
						state_q <= ST_MUL_KD;
					else
						state_q <= ST_FINAL;
				end
				ST_MUL_KD: state_q <= ST_FINAL;
				ST_FINAL: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			j_q     <= s_tdata[3:0];
			now_q   <= s_tdata[19:4];
			lo_q    <= s_tdata[35:20];
			hi_q    <= s_tdata[51:36];
			step_q  <= s_tdata[67:52];
			start_q <= s_tuser[0];
		end
		if (state_q == ST_LOAD) begin
			want_q      <= is_finger ? 17'(is_first ? shared_sat : shared_q)
			                         : 17'(tgt_base) + 17'(step_q);
			lower_q     <= (17'(lo_q) > near_lo) ? 17'(lo_q) : near_lo;
			upper_q     <= (17'(hi_q) < near_hi) ? 17'(hi_q) : near_hi;
			prev_base_q <= start_q ? now_q : prev_q[idx];
			kp_q        <= tjps_pkg::kp_gain(fast_q, gsel);
			kd2_q       <= tjps_pkg::kd2_gain(fast_q, gsel);
		end
		if (state_q == ST_CLAMP) begin
			t_q           <= t_new;
			target_q[idx] <= t_new;
			e_q           <= 17'(t_new) - 17'(now_q);
			dq_q          <= 17'(now_q) - 17'(prev_base_q);
		end
		if (state_q == ST_MUL_KP || state_q == ST_MUL_RATE || state_q == ST_MUL_KD)
			prod_q <= mul_p;
		if (state_q == ST_MUL_RATE)
			acc_q <= ACC_W'(prod_q) <<< 4;
		if (out_load) begin
			prev_q[idx] <= (mode_q == tjps_pkg::MODE_TORQUE) ? now_q : prev_base_q;
			jout_q      <= j_q;
			drive_q     <= drive_sat;
			clamped_q   <= t_q;
		end
		if (state_q == ST_LOAD && is_first)
			shared_q <= shared_sat;
		else if (fix_q) begin
			if (shared_q > span_hi_q)
				shared_q <= span_hi_q;
			else if (shared_q < span_lo_q)
				shared_q <= span_lo_q;
		end
	end

	// finger span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_hi_q <= 16'sh8000;
			span_lo_q <= 16'sh7fff;
		end else if (state_q == ST_CLAMP && is_finger) begin
			if (is_first) begin
				span_hi_q <= t_new;
				span_lo_q <= t_new;
			end else begin
				if (t_new > span_hi_q)
					span_hi_q <= t_new;
				if (t_new < span_lo_q)
					span_lo_q <= t_new;
			end
		end
	end

	// output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, clamped_q, drive_q, jout_q};

	// checks
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && in_range) |=> !s_tready)
		else $error("servo took a beat while busy");

	a_span_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLAMP && is_first) |=> (span_hi_q == span_lo_q))
		else $error("finger span not reset on first finger");

	a_pos_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && mode_q == tjps_pkg::MODE_POS)
		|=> (drive_q == {{12{clamped_q[15]}}, clamped_q, 4'd0}))
		else $error("position drive does not match clamped target");

endmodule
`default_nettype wire

/* tb/sv/servo_drive_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// servo_drive_checker : result checker for the arm joint servo
// Follows the register port and both streams, predicts every result beat from
// its own copy of the joint targets, previous angles and finger span, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module servo_drive_checker #(
	parameter int JOINTS = 9
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_wdata,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [71:0] s_tdata,
	input  wire  [0:0]  s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [55:0] m_tdata,
	output int          fail_count,
	output int          beats_owed
);

	localparam int FINGER0 = JOINTS - 3;
	localparam int REACH   = 214;	// 3 degrees in Q3.12

	// joint in the low bits, as on m_tdata
	typedef struct packed {
		logic [15:0] target;
		logic [31:0] drive;
		logic [3:0]  joint;
	} servo_beat_t;

	servo_beat_t owed_q[$];
	servo_beat_t got;
	servo_beat_t want;

	int          aim [JOINTS];
	int          last_angle [JOINTS];
	int          finger_aim;
	int          span_top;
	int          span_bottom;
	logic [1:0]  mode;
	logic        stiff;
	longint      rate;
	int          k;
	int          result_no;

	function automatic int reach_clamp(input int q, input int now, input int lo,
			input int hi);
		int lower;
		int upper;
		lower = now - REACH;
		upper = now + REACH;
		if (lo > lower) lower = lo;
		if (hi < upper) upper = hi;
		if (q < lower) return lower;
		if (q > upper) return upper;
		return q;
	endfunction

	function automatic longint sat_word(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void servo_gains(input logic hard, input int g,
			output longint kp, output longint kd2);
		case (g)
			0, 1: begin
				kp  = hard ? 1000 : 400;
				kd2 = hard ? 200 : 60;
			end
			2: begin
				kp  = hard ? 600 : 150;
				kd2 = hard ? 120 : 30;
			end
			3, 4: begin
				kp  = hard ? 300 : 60;
				kd2 = hard ? 60 : 10;
			end
			5: begin
				kp  = hard ? 250 : 60;
				kd2 = hard ? 50 : 10;
			end
			default: begin
				kp  = hard ? 30 : 5;
				kd2 = hard ? 6 : 1;
			end
		endcase
	endfunction

	// updates the joint state and returns the result beat for one input beat
	function automatic servo_beat_t predict_drive(input int j, input logic st,
			input int now, input int lo, input int hi, input int stp);
		int          t;
		int          g;
		int          s;
		longint      e;
		longint      dq;
		longint      kp;
		longint      kd2;
		longint      drv;
		servo_beat_t r;
		if (st) begin
			aim[j] = now;
			last_angle[j] = now;
			if (j == FINGER0) finger_aim = now;
		end
		if (j >= FINGER0) begin
			if (j == FINGER0) begin
				s = finger_aim + stp;
				if (s > 32767) s = 32767;
				if (s < -32768) s = -32768;
				finger_aim = s;
				span_top = -32768;
				span_bottom = 32767;
			end
			t = reach_clamp(finger_aim, now, lo, hi);
			if (t > span_top) span_top = t;
			if (t < span_bottom) span_bottom = t;
			if (j == JOINTS - 1) begin
				if (finger_aim > span_top) finger_aim = span_top;
				else if (finger_aim < span_bottom) finger_aim = span_bottom;
			end
			g = 6;
		end else begin
			t = reach_clamp(aim[j] + stp, now, lo, hi);
			g = (j > 5) ? 5 : j;
		end
		aim[j] = t;
		e = longint'(t) - longint'(now);
		drv = 0;
		case (mode)
			tjps_pkg::MODE_TORQUE: begin
				servo_gains(stiff, g, kp, kd2);
				dq = longint'(now) - longint'(last_angle[j]);
				drv = sat_word(kp * e * 16 - kd2 * dq * rate * 8);
				last_angle[j] = now;
			end
			tjps_pkg::MODE_VEL: drv = sat_word(e * rate * 8);
			tjps_pkg::MODE_POS: drv = longint'(t) * 16;
			default: drv = 0;
		endcase
		r.joint  = j[3:0];
		r.drive  = drv[31:0];
		r.target = t[15:0];
		return r;
	endfunction

	task automatic report_miss(input string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t result beat %0d: %s: expected joint %0d drive %0d target %0d,",
				$time, result_no, what, want.joint, $signed(want.drive),
				$signed(want.target));
			$display("  got joint %0d drive %0d target %0d", got.joint,
				$signed(got.drive), $signed(got.target));
		end
	endtask

	initial begin
		fail_count = 0;
		beats_owed = 0;
		result_no = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			beats_owed = 0;
			mode = tjps_pkg::MODE_TORQUE;
			stiff = 1'b0;
			rate = 1000;
			for (k = 0; k < JOINTS; k++) begin
				aim[k] = 0;
				last_angle[k] = 0;
			end
			finger_aim = 0;
			span_top = -32768;
			span_bottom = 32767;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tjps_pkg::CFG_DRIVE_MODE: mode = cfg_wdata[1:0];
					tjps_pkg::CFG_FAST_GAIN:  stiff = cfg_wdata[0];
					tjps_pkg::CFG_STEP_RATE:  rate = longint'(cfg_wdata);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[51:0];
				if (owed_q.size() == 0) begin
					want = '0;
					report_miss("no beat expected");
				end else begin
					want = owed_q.pop_front();
					if (got.joint !== want.joint || got.drive !== want.drive ||
							got.target !== want.target)
						report_miss("mismatch");
				end
				result_no++;
			end
			if (s_tvalid && s_tready && s_tdata[3:0] < JOINTS)
				owed_q.insert(owed_q.size(), predict_drive(int'(s_tdata[3:0]),
					s_tuser[0], int'($signed(s_tdata[19:4])),
					int'($signed(s_tdata[35:20])), int'($signed(s_tdata[51:36])),
					int'($signed(s_tdata[67:52]))));
			beats_owed = owed_q.size();
		end
	end

endmodule
`default_nettype wire

/* tb/sv/teleop_joint_pd_servo_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// teleop_joint_pd_servo_test : regression for the arm joint servo
// Directed ticks for the field extremes, inverted limits, shared finger
// overflow and dropped joint indexes, then randomised control ticks across
// all drive modes, both gain tables and the rate extremes, with random gaps
// on the input stream and random back-pressure on the result stream.
// ----------------------------------------------------------------------------
module teleop_joint_pd_servo_test;

	localparam int         JOINTS      = 9;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         SETTLE      = 24;
	localparam int         PHASES      = 12;
	localparam int         PHASE_BEATS = 64;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	wire         s_tready;
	// joint_index, angle_now, angle_low_limit, angle_high_limit, target_step, zero
	logic [71:0] s_tdata;
	// start_req
	logic [0:0]  s_tuser;
	wire         m_tvalid;
	logic        m_tready;
	// joint_out, drive_value, clamped_target, zero
	wire  [55:0] m_tdata;
	int          fail_count;
	int          beats_owed;

	int          cycle_count;
	int          drift [JOINTS];
	logic        calm;
	int          beats_in_phase;
	int          p;
	int          j;
	int          r;
	int          now;
	logic [1:0]  plan_mode;
	logic        plan_stiff;
	logic [15:0] plan_rate;

	always #6 clk = ~clk;

	teleop_joint_pd_servo #(
		.JOINT_COUNT(JOINTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	servo_drive_checker #(
		.JOINTS(JOINTS)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.beats_owed(beats_owed)
	);

	function automatic int pick_gap();
		int g;
		g = $urandom_range(0, 99);
		if (g < 45) return 0;
		if (g < 85) return $urandom_range(1, 3);
		if (g < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int q16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int rand_word();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic push_beat(input logic [3:0] jidx, input logic st, input int a_now,
			input int lo, input int hi, input int stp);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, stp[15:0], hi[15:0], lo[15:0], a_now[15:0], jidx};
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic push_random_joint(input int jj, input logic st);
		int sel;
		int a_now;
		int lo;
		int hi;
		int stp;
		sel = $urandom_range(0, 99);
		if (sel < 70) a_now = q16(drift[jj] + int'($urandom_range(0, 800)) - 400);
		else a_now = rand_word();
		drift[jj] = a_now;
		sel = $urandom_range(0, 99);
		if (sel < 65) begin
			lo = q16(a_now - int'($urandom_range(0, 3000)));
			hi = q16(a_now + int'($urandom_range(0, 3000)));
		end else if (sel < 80) begin
			lo = -32768;
			hi = 32767;
		end else begin
			lo = rand_word();
			hi = rand_word();
		end
		sel = $urandom_range(0, 99);
		if (sel < 50) stp = int'($urandom_range(0, 600)) - 300;
		else if (sel < 80) stp = int'($urandom_range(0, 6000)) - 3000;
		else stp = rand_word();
		push_beat(jj[3:0], st, a_now, lo, hi, stp);
		beats_in_phase++;
	endtask

	task automatic push_tick();
		int jj;
		calm = ($urandom_range(0, 4) == 0);
		for (jj = 0; jj < JOINTS; jj++)
			push_random_joint(jj, $urandom_range(0, 24) == 0);
		calm = 1'b0;
	endtask

	task automatic set_config(input logic [1:0] m, input logic stiff, input logic [15:0] rate);
		logic [15:0] junk;
		junk = 16'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= tjps_pkg::CFG_DRIVE_MODE;
		cfg_wdata <= {junk[15:2], m};
		@(posedge clk);
		junk = 16'($urandom);
		cfg_index <= tjps_pkg::CFG_FAST_GAIN;
		cfg_wdata <= {junk[15:1], stiff};
		@(posedge clk);
		cfg_index <= tjps_pkg::CFG_STEP_RATE;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every owed result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side back-pressure
	initial begin
		m_tready <= 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else if (r < 60) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(100, 300)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("teleop_joint_pd_servo regression: fail");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tjps_pkg::CFG_DRIVE_MODE;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		calm = 1'b0;
		beats_in_phase = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start tick: every joint loaded, extremes on the first two
		for (j = 0; j < JOINTS; j++) begin
			now = (j == 0) ? -32768 : (j == 1) ? 32767 : j * 1500 - 6000;
			drift[j] = now;
			push_beat(j[3:0], 1'b1, now, -32768, 32767, (j == 2) ? 100 : 0);
		end
		// field extremes, inverted limits, large derivative, shared overflow
		push_beat(4'd0, 1'b0, -32768, -32768, 32767, -32768);
		push_beat(4'd1, 1'b0, 32767, -32768, 32767, 32767);
		push_beat(4'd2, 1'b0, 0, 1000, -1000, 0);
		push_beat(4'd3, 1'b0, 32000, -32768, 32767, 0);
		push_beat(4'd4, 1'b0, drift[4] + 50, -32768, 32767, 40);
		push_beat(4'd5, 1'b0, drift[5], -32768, 32767, 5000);
		push_beat(4'd6, 1'b0, drift[6], -32768, 32767, 32767);
		push_beat(4'd7, 1'b0, drift[7], drift[7] - 100, drift[7] + 100, 0);
		push_beat(4'd8, 1'b0, drift[8], -32768, 32767, 0);
		// dropped joint indexes
		push_beat(4'd9, 1'b0, 100, -100, 100, 5);
		push_beat(4'd15, 1'b1, -1, -1, -1, -1);
		// start on the first finger mid-tick, negative shared overflow
		push_beat(4'd6, 1'b1, -500, -32768, 32767, -32768);
		push_beat(4'd7, 1'b1, 200, -32768, 32767, 0);
		push_beat(4'd8, 1'b0, drift[8], drift[8] - 20, drift[8] + 300, 0);
		push_beat(4'd3, 1'b1, -32768, -32768, -32000, 700);
		drift[3] = -32768;
		drift[6] = -500;
		drift[7] = 200;

		for (p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					plan_mode = tjps_pkg::MODE_TORQUE; plan_stiff = 1'b1;
					plan_rate = 16'd1000;
				end
				1: begin
					plan_mode = tjps_pkg::MODE_TORQUE; plan_stiff = 1'b0;
					plan_rate = 16'd65535;
				end
				2: begin
					plan_mode = tjps_pkg::MODE_VEL; plan_stiff = 1'b0;
					plan_rate = 16'd1;
				end
				3: begin
					plan_mode = tjps_pkg::MODE_VEL; plan_stiff = 1'b1;
					plan_rate = 16'd65535;
				end
				4: begin
					plan_mode = tjps_pkg::MODE_POS; plan_stiff = 1'b0;
					plan_rate = 16'd1000;
				end
				5: begin
					plan_mode = MODE_SPARE; plan_stiff = 1'b1;
					plan_rate = 16'd500;
				end
				6: begin
					plan_mode = tjps_pkg::MODE_TORQUE; plan_stiff = 1'b1;
					plan_rate = 16'd0;
				end
				7: begin
					plan_mode = tjps_pkg::MODE_VEL; plan_stiff = 1'b0;
					plan_rate = 16'd0;
				end
				8: begin
					plan_mode = tjps_pkg::MODE_TORQUE; plan_stiff = 1'b0;
					plan_rate = 16'd1;
				end
				9: begin
					plan_mode = tjps_pkg::MODE_POS; plan_stiff = 1'b1;
					plan_rate = 16'd65535;
				end
				10: begin
					plan_mode = tjps_pkg::MODE_TORQUE; plan_stiff = 1'b1;
					plan_rate = 16'($urandom_range(1, 65535));
				end
				default: begin
					plan_mode = tjps_pkg::MODE_VEL; plan_stiff = 1'b1;
					plan_rate = 16'($urandom_range(1, 65535));
				end
			endcase
			set_config(plan_mode, plan_stiff, plan_rate);
			beats_in_phase = 0;
			while (beats_in_phase < PHASE_BEATS) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					push_tick();
				end else if (r < 90) begin
					push_random_joint($urandom_range(0, JOINTS - 1), $urandom_range(0, 9) == 0);
				end else begin
					push_beat(4'($urandom_range(JOINTS, 15)), 1'($urandom), rand_word(),
						rand_word(), rand_word(), rand_word());
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("teleop_joint_pd_servo regression: pass");
		else
			$display("teleop_joint_pd_servo regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
